// ===== hw/rtl/ghid_pkg.sv =====
// shared constants and types for the ghosted index decomposer
package ghid_pkg;

    // index and field widths
    localparam int INDEX_BITS = 24;
    localparam int EXT_W      = 13;
    localparam int GHOST_W    = 3;
    localparam int PAD_W      = 14;
    localparam int CX_W       = 14;
    localparam int CZ_W       = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_X     = 3'd0,
        REG_EXTENT_Y     = 3'd1,
        REG_EXTENT_Z     = 3'd2,
        REG_GHOST_X_LOW  = 3'd3,
        REG_GHOST_X_HIGH = 3'd4,
        REG_GHOST_Y_LOW  = 3'd5,
        REG_GHOST_Y_HIGH = 3'd6,
        REG_GHOST_Z_LOW  = 3'd7
    } ghid_reg_t;

    // pipeline control travelling into a divider
    typedef struct packed {
        logic en;
        logic valid;
    } ghid_ctl_t;

endpackage

// ===== hw/rtl/ghid_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module ghid_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ghid_pkg::ghid_ctl_t               ctl,
    input  logic [ghid_pkg::INDEX_BITS-1:0]   in_dividend,
    input  logic [ghid_pkg::PAD_W-1:0]        divisor,
    input  logic [ghid_pkg::PAD_W-1:0]        in_side,
    output logic                              out_valid,
    output logic [ghid_pkg::INDEX_BITS-1:0]   out_quot,
    output logic [ghid_pkg::PAD_W-1:0]        out_rem,
    output logic [ghid_pkg::PAD_W-1:0]        out_side
);

    localparam int DW = ghid_pkg::INDEX_BITS;
    localparam int RW = ghid_pkg::PAD_W;

    logic          valid_reg [DW];
    logic [DW-1:0] work_reg  [DW];
    logic [RW-1:0] rem_reg   [DW];
    logic [RW-1:0] side_reg  [DW];
    logic [DW-1:0] work_next [DW];
    logic [RW-1:0] rem_next  [DW];

    // one compare and subtract per stage
    genvar k;
    for (k = 0; k < DW; k++) begin : g_stage
        logic [DW-1:0] work_src;
        logic [RW-1:0] rem_src;
        logic [RW:0]   part;
        logic [RW:0]   diff;
        logic          take;

        if (k == 0) begin : g_first
            assign work_src = in_dividend;
            assign rem_src  = '0;
        end else begin : g_rest
            assign work_src = work_reg[k-1];
            assign rem_src  = rem_reg[k-1];
        end

        assign part         = {rem_src, work_src[DW-1]};
        assign diff         = part - {1'b0, divisor};
        assign take         = (part >= {1'b0, divisor});
        assign rem_next[k]  = take ? diff[RW-1:0] : part[RW-1:0];
        assign work_next[k] = {work_src[DW-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (ctl.en) begin
                valid_reg[k] <= (k == 0) ? ctl.valid : valid_reg[k-1 < 0 ? 0 : k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ctl.en) begin
                work_reg[k] <= work_next[k];
                rem_reg[k]  <= rem_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[k-1 < 0 ? 0 : k-1];
            end
        end
    end

    // zero divisor gives quotient 0; remainder already holds the low dividend bits
    assign out_valid = valid_reg[DW-1];
    assign out_quot  = (divisor == '0) ? '0 : work_reg[DW-1];
    assign out_rem   = rem_reg[DW-1];
    assign out_side  = side_reg[DW-1];

endmodule

// ===== hw/rtl/ghosted_index_decompose.sv =====
// top level: linear index to ghost-aware x, y, z coordinates
// Each word on s_linear_index yields one result word on the m_ side. The
// block is fully pipelined and takes a new index every cycle while the
// output is not stalled. It has 24 stages for the division by the padded x
// size, 24 for the division of that quotient by the padded y size (one
// quotient bit per stage), and one output register for the coordinate
// offsets and ghost checks. A stall on m_ready holds the whole pipeline.
// Registers are written through cfg_wr_en/cfg_index/cfg_data and must only
// change while no words are in flight.
module ghosted_index_decompose (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ghid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ghid_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ghid_pkg::INDEX_BITS-1:0]     s_linear_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_ghost,
    output logic signed [ghid_pkg::CX_W-1:0]    m_coord_x,
    output logic signed [ghid_pkg::CX_W-1:0]    m_coord_y,
    output logic signed [ghid_pkg::CZ_W-1:0]    m_coord_z
);

    localparam int EW = ghid_pkg::EXT_W;
    localparam int GW = ghid_pkg::GHOST_W;
    localparam int PW = ghid_pkg::PAD_W;
    localparam int DW = ghid_pkg::INDEX_BITS;

    logic [EW-1:0] extent_x_reg, extent_y_reg, extent_z_reg;
    logic [GW-1:0] gxl_reg, gxh_reg, gyl_reg, gyh_reg, gzl_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extent_x_reg <= EW'(1);
            extent_y_reg <= EW'(1);
            extent_z_reg <= EW'(1);
            gxl_reg      <= '0;
            gxh_reg      <= '0;
            gyl_reg      <= '0;
            gyh_reg      <= '0;
            gzl_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (ghid_pkg::ghid_reg_t'(cfg_index))
                ghid_pkg::REG_EXTENT_X:     extent_x_reg <= cfg_data;
                ghid_pkg::REG_EXTENT_Y:     extent_y_reg <= cfg_data;
                ghid_pkg::REG_EXTENT_Z:     extent_z_reg <= cfg_data;
                ghid_pkg::REG_GHOST_X_LOW:  gxl_reg <= cfg_data[GW-1:0];
                ghid_pkg::REG_GHOST_X_HIGH: gxh_reg <= cfg_data[GW-1:0];
                ghid_pkg::REG_GHOST_Y_LOW:  gyl_reg <= cfg_data[GW-1:0];
                ghid_pkg::REG_GHOST_Y_HIGH: gyh_reg <= cfg_data[GW-1:0];
                ghid_pkg::REG_GHOST_Z_LOW:  gzl_reg <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // padded sizes
    logic [PW-1:0] nx, ny;
    assign nx = PW'(extent_x_reg) + PW'(gxl_reg) + PW'(gxh_reg);
    assign ny = PW'(extent_y_reg) + PW'(gyl_reg) + PW'(gyh_reg);

    // global advance: the pipeline moves unless the output word is stuck
    logic      adv;
    logic      m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    ghid_pkg::ghid_ctl_t ctl1, ctl2;
    logic          v1, v2;
    logic [DW-1:0] q1, q2;
    logic [PW-1:0] r1, r2, side1_unused, rx2;

    assign ctl1 = '{en: adv, valid: s_valid};

    // first division: by the padded x size
    ghid_div u_div_x (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl1),
        .in_dividend (s_linear_index),
        .divisor     (nx),
        .in_side     ('0),
        .out_valid   (v1),
        .out_quot    (q1),
        .out_rem     (r1),
        .out_side    (side1_unused)
    );

    assign ctl2 = '{en: adv, valid: v1};

    // second division: by the padded y size, x remainder rides alongside
    ghid_div u_div_y (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl2),
        .in_dividend (q1),
        .divisor     (ny),
        .in_side     (r1),
        .out_valid   (v2),
        .out_quot    (q2),
        .out_rem     (r2),
        .out_side    (rx2)
    );

    // offsets and interior checks
    logic [PW:0]   cx, cy;
    logic [DW:0]   cz;
    logic          y_on, z_on, gx, gy, gz;
    assign cx   = {1'b0, rx2} - (PW+1)'(gxl_reg) + (PW+1)'(side1_unused & '0);
    assign cy   = {1'b0, r2} - (PW+1)'(gyl_reg);
    assign cz   = {1'b0, q2} - (DW+1)'(gzl_reg);
    assign y_on = extent_y_reg > EW'(1);
    assign z_on = extent_z_reg > EW'(1);
    assign gx   = cx[PW] || (cx[PW-1:0] >= PW'(extent_x_reg));
    assign gy   = y_on && (cy[PW] || (cy[PW-1:0] >= PW'(extent_y_reg)));
    assign gz   = z_on && (cz[DW] || (cz[DW-1:0] >= DW'(extent_z_reg)));

    // output register
    logic                   is_ghost_reg;
    logic [PW-1:0]          cx_reg, cy_reg;
    logic [DW:0]            cz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v2;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            is_ghost_reg <= gx || gy || gz;
            cx_reg       <= cx[PW-1:0];
            cy_reg       <= y_on ? cy[PW-1:0] : '1;
            cz_reg       <= z_on ? cz : '1;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_is_ghost = is_ghost_reg;
    assign m_coord_x  = $signed(cx_reg);
    assign m_coord_y  = $signed(cy_reg);
    assign m_coord_z  = $signed(cz_reg);

    // checks
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("ready does not follow output stall");

    a_y_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && extent_y_reg == EW'(1)) |-> (m_coord_y == -14'sd1))
        else $error("disabled y axis not reporting minus one");

    a_x_ghost: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_coord_x < 0)) |-> m_is_ghost)
        else $error("negative x coordinate without ghost flag");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2 && !adv) |=> v2)
        else $error("word lost in divider pipeline during stall");

endmodule
